FILE: hw/rtl/itpt_pkg.sv
package itpt_pkg;

	// Field bounds
	localparam int MAX_FIELD = 64;
	localparam int LEN_W     = 7;
	localparam int DIG_DEPTH = 16;
	localparam int DIG_IDX_W = 4;

	// Reciprocal of ten: floor(v * RECIP_TEN / 2**RECIP_SHIFT) == v / 10 for 32-bit v
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Conversion codes
	localparam logic OP_DEC = 1'b0;
	localparam logic OP_HEX = 1'b1;

	// ASCII constants
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOWA  = 8'h61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIG,
		ST_SIZE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic dig;
		logic size;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic len_zero;
		logic last;
		logic is_hex;
	} status_t;

	// Map one digit to lower-case ASCII
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = CH_LOWA + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/itpt_ctrl.sv
module itpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  itpt_pkg::status_t status,
	output itpt_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              strobe
);

	itpt_pkg::state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance through conversion, sizing and emission
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itpt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (op == itpt_pkg::OP_HEX) ? itpt_pkg::ST_DIG : itpt_pkg::ST_MUL;
				end
			end
			itpt_pkg::ST_MUL: begin
				state_d = itpt_pkg::ST_DIG;
			end
			itpt_pkg::ST_DIG: begin
				if (status.conv_done) begin
					state_d = itpt_pkg::ST_SIZE;
				end else if (!status.is_hex) begin
					state_d = itpt_pkg::ST_MUL;
				end
			end
			itpt_pkg::ST_SIZE: begin
				state_d = status.len_zero ? itpt_pkg::ST_IDLE : itpt_pkg::ST_EMIT;
			end
			itpt_pkg::ST_EMIT: begin
				if (status.last) begin
					state_d = itpt_pkg::ST_IDLE;
				end
			end
			default: state_d = itpt_pkg::ST_IDLE;
		endcase
	end

	// Drive datapath commands
	always_comb begin
		cmd    = '0;
		busy   = 1'b1;
		strobe = 1'b0;
		unique case (state_q)
			itpt_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			itpt_pkg::ST_MUL:  cmd.mul  = 1'b1;
			itpt_pkg::ST_DIG:  cmd.dig  = 1'b1;
			itpt_pkg::ST_SIZE: cmd.size = 1'b1;
			itpt_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				strobe   = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

FILE: hw/rtl/itpt_dpath.sv
module itpt_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  itpt_pkg::cmd_t    cmd,
	input  logic              op,
	input  logic [31:0]       value,
	input  logic [6:0]        field_width,
	input  logic              precision_given,
	input  logic [5:0]        precision,
	output itpt_pkg::status_t status,
	output logic [7:0]        text_char,
	output logic              last_char
);

	localparam int LW = itpt_pkg::LEN_W;
	localparam logic [LW-1:0] WIDTH_MAX = LW'(itpt_pkg::MAX_FIELD);
	localparam logic [LW-1:0] PREC_MAX  = LW'(itpt_pkg::MAX_FIELD - 1);

	// Request registers
	logic [31:0]   val_q;
	logic          neg_q;
	logic          hex_q;
	logic          prec_on_q;
	logic          drop_q;
	logic [LW-1:0] width_q;
	logic [LW-1:0] prec_q;

	// Digit store and conversion state
	logic [3:0]    digs_q [itpt_pkg::DIG_DEPTH];
	logic [3:0]    ndig_q;
	logic [63:0]   prod_s1;

	// Emission boundaries
	logic [LW-1:0] b_space_q, b_sign_q, b_zero_q, len_q, pos_q;

	// Load-time values
	logic          neg_in;
	logic [31:0]   mag_in;
	logic [LW-1:0] width_in, prec_in;

	always_comb begin
		neg_in   = (op == itpt_pkg::OP_DEC) && value[31];
		mag_in   = neg_in ? (32'd0 - value) : value;
		width_in = (field_width > WIDTH_MAX) ? WIDTH_MAX : field_width;
		prec_in  = (LW'(precision) > PREC_MAX) ? PREC_MAX : LW'(precision);
	end

	// Next digit and quotient
	logic [28:0] quot;
	logic [31:0] rem_full;
	logic [31:0] val_next;
	logic [3:0]  dig_next;

	always_comb begin
		quot     = prod_s1[63:itpt_pkg::RECIP_SHIFT];
		rem_full = val_q - ({3'd0, quot} << 3) - ({3'd0, quot} << 1);
		if (hex_q) begin
			val_next = {4'd0, val_q[31:4]};
			dig_next = val_q[3:0];
		end else begin
			val_next = {3'd0, quot};
			dig_next = rem_full[3:0];
		end
	end

	// Size the padded text
	logic [LW-1:0] nd, body, spaces, zeros, b2, b3, len_d;
	logic          pad_on;

	always_comb begin
		nd     = drop_q ? '0 : LW'(ndig_q);
		pad_on = prec_on_q && (prec_q > nd);
		body   = (pad_on ? prec_q : nd) + LW'(neg_q);
		spaces = (width_q > body) ? (width_q - body) : '0;
		zeros  = pad_on ? (prec_q - nd) : '0;
		b2     = spaces + LW'(neg_q);
		b3     = b2 + zeros;
		len_d  = b3 + nd;
	end

	// Latch request and run conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
			pos_q  <= '0;
		end else begin
			if (cmd.load) begin
				ndig_q <= '0;
			end else if (cmd.dig) begin
				ndig_q <= ndig_q + 4'd1;
			end
			if (cmd.size) begin
				pos_q <= '0;
			end else if (cmd.emit) begin
				pos_q <= pos_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q     <= mag_in;
			neg_q     <= neg_in;
			hex_q     <= (op == itpt_pkg::OP_HEX);
			prec_on_q <= precision_given;
			drop_q    <= (mag_in == 32'd0) && precision_given && (precision == 6'd0);
			width_q   <= width_in;
			prec_q    <= prec_in;
		end
		if (cmd.mul) begin
			prod_s1 <= {32'd0, val_q} * {32'd0, itpt_pkg::RECIP_TEN};
		end
		if (cmd.dig) begin
			digs_q[ndig_q] <= dig_next;
			val_q          <= val_next;
		end
		if (cmd.size) begin
			b_space_q <= spaces;
			b_sign_q  <= b2;
			b_zero_q  <= b3;
			len_q     <= len_d;
		end
	end

	// Pick the character at the current position
	logic [LW-1:0] dig_pos;

	always_comb begin
		dig_pos = len_q - LW'(1) - pos_q;
		if (pos_q < b_space_q) begin
			text_char = itpt_pkg::CH_SPACE;
		end else if (pos_q < b_sign_q) begin
			text_char = itpt_pkg::CH_MINUS;
		end else if (pos_q < b_zero_q) begin
			text_char = itpt_pkg::CH_ZERO;
		end else begin
			text_char = itpt_pkg::digit_char(digs_q[dig_pos[itpt_pkg::DIG_IDX_W-1:0]]);
		end
		last_char = (pos_q == len_q - LW'(1));
	end

	// Report status
	always_comb begin
		status.conv_done = (val_next == 32'd0);
		status.len_zero  = (len_d == '0);
		status.last      = last_char;
		status.is_hex    = hex_q;
	end

endmodule

FILE: hw/rtl/integer_to_padded_text_unit.sv
// Integer to padded text: one printf-style %d or %x conversion per request.
// Request channel: drive op, value, field_width, precision_given and
// precision with start high; the request is taken at a clock edge where
// start is high and busy is low. Busy stays high until the last character
// of that request has been shown.
// Result channel: each ASCII character appears on text_char for exactly one
// cycle with strobe high, most significant character first; last_char marks
// the final one. Characters of one request come in consecutive cycles.
// The receiver cannot stall: every strobed character is taken as shown.
// Conversion: hex takes one step per digit, decimal two per digit (a
// reciprocal multiply by ten, then quotient and remainder), then a sizing
// step; the first character follows in the next cycle. A request has up
// to 8 (hex) or 10 (decimal) digits and a text of up to 64 characters.
// An empty text produces no strobe and frees the unit once it is sized.
// Reset (arst_n low) returns the unit to idle at once; no clearing is needed.
module integer_to_padded_text_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] value,
	input  logic [6:0]  field_width,
	input  logic        precision_given,
	input  logic [5:0]  precision,
	output logic        strobe,
	output logic [7:0]  text_char,
	output logic        last_char
);

	itpt_pkg::cmd_t    cmd;
	itpt_pkg::status_t status;

	itpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	itpt_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.op              (op),
		.value           (value),
		.field_width     (field_width),
		.precision_given (precision_given),
		.precision       (precision),
		.status          (status),
		.text_char       (text_char),
		.last_char       (last_char)
	);

endmodule

FILE: hw/rtl/itpt_checker.sv
module itpt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last_char
);

	// A taken request keeps the unit busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but unit not busy");

	// Characters only while a request is in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("character shown while idle");

	// Characters of one request are contiguous
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_char |=> strobe)
		else $error("gap inside a text");

	// Last character ends the text and frees the unit
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_char |=> !strobe && !busy)
		else $error("text continues after last character");

endmodule

bind integer_to_padded_text_unit itpt_checker u_itpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.last_char (last_char)
);

FILE: verif/integer_to_padded_text_unit_tb.sv
module integer_to_padded_text_unit_tb;

	localparam int RANDOM_ITEMS   = 95;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int REPORT_LIMIT   = 10;
	localparam string DIGIT_GLYPHS = "0123456789abcdef";

	typedef struct packed {
		logic        op;
		logic [31:0] value;
		logic [6:0]  field_width;
		logic        precision_given;
		logic [5:0]  precision;
	} text_request_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_beat_t;

	typedef logic [7:0] char_q_t[$];

	// directed row: request, and the text where it is typed in by hand
	typedef struct {
		text_request_t req;
		bit            typed;
		string         text;
	} directed_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        op = itpt_pkg::OP_DEC;
	logic [31:0] value = '0;
	logic [6:0]  field_width = '0;
	logic        precision_given = 1'b0;
	logic [5:0]  precision = '0;
	logic        strobe;
	logic [7:0]  text_char;
	logic        last_char;

	text_beat_t expected_text_q[$];
	int         mismatch_count = 0;
	int         idle_cycles = 0;

	directed_row_t directed_rows[25] = '{
		'{'{itpt_pkg::OP_DEC, 32'd0,          7'd0,   1'b0, 6'd0},  1'b1, "0"},
		'{'{itpt_pkg::OP_DEC, 32'd0,          7'd0,   1'b1, 6'd0},  1'b1, ""},
		'{'{itpt_pkg::OP_DEC, 32'd0,          7'd5,   1'b1, 6'd0},  1'b1, "     "},
		'{'{itpt_pkg::OP_HEX, 32'd0,          7'd0,   1'b1, 6'd0},  1'b1, ""},
		'{'{itpt_pkg::OP_DEC, 32'h8000_0000,  7'd0,   1'b0, 6'd0},  1'b1, "-2147483648"},
		'{'{itpt_pkg::OP_DEC, 32'hFFFF_FFFF,  7'd0,   1'b0, 6'd0},  1'b1, "-1"},
		'{'{itpt_pkg::OP_DEC, 32'h7FFF_FFFF,  7'd0,   1'b0, 6'd0},  1'b1, "2147483647"},
		'{'{itpt_pkg::OP_HEX, 32'hFFFF_FFFF,  7'd0,   1'b0, 6'd0},  1'b1, "ffffffff"},
		'{'{itpt_pkg::OP_HEX, 32'hDEAD_BEEF,  7'd12,  1'b0, 6'd0},  1'b1, "    deadbeef"},
		'{'{itpt_pkg::OP_HEX, 32'h0123_ABCD,  7'd1,   1'b0, 6'd0},  1'b1, "123abcd"},
		'{'{itpt_pkg::OP_DEC, 32'hFFFF_FFF9,  7'd6,   1'b1, 6'd3},  1'b1, "  -007"},
		'{'{itpt_pkg::OP_HEX, 32'd255,        7'd0,   1'b1, 6'd4},  1'b1, "00ff"},
		'{'{itpt_pkg::OP_DEC, 32'd9,          7'd0,   1'b1, 6'd0},  1'b1, "9"},
		'{'{itpt_pkg::OP_DEC, 32'd5,          7'd2,   1'b0, 6'd63}, 1'b1, " 5"},
		'{'{itpt_pkg::OP_DEC, 32'd12345,      7'd3,   1'b0, 6'd0},  1'b1, "12345"},
		'{'{itpt_pkg::OP_DEC, 32'd1000000000, 7'd0,   1'b0, 6'd0},  1'b1, "1000000000"},
		'{'{itpt_pkg::OP_HEX, 32'h8000_0000,  7'd0,   1'b0, 6'd0},  1'b1, "80000000"},
		'{'{itpt_pkg::OP_HEX, 32'd0,          7'd0,   1'b1, 6'd1},  1'b1, "0"},
		'{'{itpt_pkg::OP_DEC, 32'd42,         7'd127, 1'b0, 6'd0},  1'b0, ""},
		'{'{itpt_pkg::OP_HEX, 32'd0,          7'd64,  1'b0, 6'd0},  1'b0, ""},
		'{'{itpt_pkg::OP_DEC, 32'd7,          7'd65,  1'b1, 6'd2},  1'b0, ""},
		'{'{itpt_pkg::OP_DEC, 32'hFFFF_FFFB,  7'd0,   1'b1, 6'd63}, 1'b0, ""},
		'{'{itpt_pkg::OP_HEX, 32'h0000_00A5,  7'd127, 1'b1, 6'd63}, 1'b0, ""},
		'{'{itpt_pkg::OP_DEC, 32'h8000_0000,  7'd64,  1'b1, 6'd63}, 1'b0, ""},
		'{'{itpt_pkg::OP_DEC, 32'd0,          7'd127, 1'b1, 6'd0},  1'b0, ""}
	};

	integer_to_padded_text_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.value           (value),
		.field_width     (field_width),
		.precision_given (precision_given),
		.precision       (precision),
		.strobe          (strobe),
		.text_char       (text_char),
		.last_char       (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Format one request: spaces, minus, zero padding, then digits
	function automatic void format_integer(input text_request_t req, output char_q_t text);
		logic [31:0] magnitude;
		logic        negative;
		int          width_sat;
		int          prec_sat;
		int          body;
		int          radix;
		char_q_t     digits;
		magnitude = req.value;
		negative  = 1'b0;
		text      = {};
		width_sat = (req.field_width > itpt_pkg::MAX_FIELD) ?
			itpt_pkg::MAX_FIELD : int'(req.field_width);
		prec_sat  = (req.precision > itpt_pkg::MAX_FIELD - 1) ?
			itpt_pkg::MAX_FIELD - 1 : int'(req.precision);
		radix     = (req.op == itpt_pkg::OP_HEX) ? 16 : 10;
		if (req.op == itpt_pkg::OP_DEC && req.value[31]) begin
			negative  = 1'b1;
			magnitude = -req.value;
		end
		// zero with explicit zero precision gives no digit at all
		if (magnitude == 32'd0) begin
			if (!(req.precision_given && prec_sat == 0))
				digits.push_back(itpt_pkg::CH_ZERO);
		end else begin
			while (magnitude != 32'd0) begin
				digits.push_front(DIGIT_GLYPHS[magnitude % radix]);
				magnitude = magnitude / radix;
			end
		end
		body = (req.precision_given && prec_sat > digits.size()) ? prec_sat : digits.size();
		if (negative)
			body++;
		for (int i = body; i < width_sat; i++)
			text.push_back(itpt_pkg::CH_SPACE);
		if (negative)
			text.push_back(itpt_pkg::CH_MINUS);
		if (req.precision_given) begin
			for (int i = digits.size(); i < prec_sat; i++)
				text.push_back(itpt_pkg::CH_ZERO);
		end
		foreach (digits[i])
			text.push_back(digits[i]);
	endfunction

	function automatic text_request_t random_request();
		text_request_t req;
		int unsigned   mode;
		req.op = 1'($urandom_range(0, 1));
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1, 2: req.value = $urandom;
			3, 4:    req.value = $urandom_range(0, 99);
			5:       req.value = -$urandom_range(1, 1000);
			6: begin
				case ($urandom_range(0, 4))
					0: req.value = 32'd0;
					1: req.value = 32'h8000_0000;
					2: req.value = 32'h7FFF_FFFF;
					3: req.value = 32'hFFFF_FFFF;
					default: req.value = 32'd1;
				endcase
			end
			default: req.value = $urandom >> $urandom_range(0, 31);
		endcase
		// keep most texts short, with the odd oversized width
		mode = $urandom_range(0, 99);
		if (mode < 80)
			req.field_width = 7'($urandom_range(0, 20));
		else if (mode < 95)
			req.field_width = 7'($urandom_range(0, 127));
		else
			req.field_width = 7'($urandom_range(60, 70));
		req.precision_given = 1'($urandom_range(0, 1));
		req.precision = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 12)) :
			6'($urandom_range(0, 63));
		return req;
	endfunction

	// Present one request and wait for it to be taken; queue its text on acceptance
	task automatic send_request(input text_request_t req, input bit typed, input string typed_text);
		char_q_t text;
		op              <= req.op;
		value           <= req.value;
		field_width     <= req.field_width;
		precision_given <= req.precision_given;
		precision       <= req.precision;
		start           <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (typed) begin
			for (int k = 0; k < typed_text.len(); k++)
				text.push_back(typed_text[k]);
		end else begin
			format_integer(req, text);
		end
		foreach (text[k])
			expected_text_q.push_back('{ch: text[k], last: (k == text.size() - 1)});
	endtask

	// Drop start for a random gap, or hold off until every character has come
	task automatic pace_sender(input bit drain);
		int unsigned gap;
		int unsigned roll;
		if (drain) begin
			start <= 1'b0;
			@(posedge clk);
			while (expected_text_q.size() != 0)
				@(posedge clk);
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				gap = 0;
			else if (roll < 85)
				gap = $urandom_range(1, 3);
			else if (roll < 95)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 90);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch: %s", what);
	endtask

	// Compare each strobed character with the oldest expected one
	always @(posedge clk) begin
		text_beat_t want;
		if (arst_n && strobe) begin
			if (expected_text_q.size() == 0) begin
				report_mismatch($sformatf("unexpected char 8'h%02h last %0b",
					text_char, last_char));
			end else begin
				want = expected_text_q.pop_front();
				if (text_char !== want.ch || last_char !== want.last)
					report_mismatch($sformatf("char expected 8'h%02h last %0b, got 8'h%02h last %0b",
						want.ch, want.last, text_char, last_char));
			end
		end
	end

	// Abort when no request is taken for too long
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d characters outstanding", expected_text_q.size());
			$display("** integer_to_padded_text_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, then drain before the random part
		foreach (directed_rows[r]) begin
			send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].text);
			pace_sender(r == $size(directed_rows) - 1);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_request(random_request(), 1'b0, "");
			pace_sender(n == RANDOM_ITEMS / 2 || n == RANDOM_ITEMS - 1);
		end

		// let any stray characters show up before judging
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_text_q.size() == 0) begin
			$display("** integer_to_padded_text_unit: PASSED **");
		end else begin
			$display("** integer_to_padded_text_unit: FAILED **");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/itpt_pkg.sv
hw/rtl/itpt_ctrl.sv
hw/rtl/itpt_dpath.sv
hw/rtl/integer_to_padded_text_unit.sv
hw/rtl/itpt_checker.sv
verif/integer_to_padded_text_unit_tb.sv
